// ----- sv/ordered_slot_pool_unit_defines.svh -----
// Assertion macros for the ordered slot pool unit.
// Expects clk and rst_n in the scope of each use.
`ifndef ORDERED_SLOT_POOL_UNIT_DEFINES_SVH
`define ORDERED_SLOT_POOL_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OSP_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define OSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/osp_pkg.sv -----
// Shared types and constants for the ordered slot pool unit.
// No dependencies; imported by the interfaces and every module.
package osp_pkg;

  localparam int OP_W      = 3;
  localparam int POS_W     = 6;
  localparam int WD_W      = 32;
  localparam int RD_W      = 32;
  localparam int SLOT_W    = 6;
  localparam int CNT_OUT_W = 7;
  localparam int ST_W      = 2;

  typedef logic [OP_W-1:0] op_code_t;
  typedef logic [ST_W-1:0] status_t;

  localparam op_code_t OP_APPEND = 3'd0;
  localparam op_code_t OP_INSERT = 3'd1;
  localparam op_code_t OP_DELETE = 3'd2;
  localparam op_code_t OP_GET    = 3'd3;
  localparam op_code_t OP_SET    = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;       // free-map clearing pass
    logic capture;      // latch the input item
    logic setup;        // decode: bounds, status, scanner reset
    logic lookup;       // read index at position
    logic access;       // payload read/write, free for delete
    logic shift_en;     // move index entries
    logic scan_en;      // search for lowest free slot
    logic place;        // write new entry
    logic load_result;  // fill the output register
  } osp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_acc;
    logic is_del;
    logic full;
    logic in_range;
    logic sh_busy;
    logic found;
    logic out_free;
  } osp_stat_t;

endpackage

// ----- sv/osp_if.sv -----
// Valid/ready channel interfaces for the ordered slot pool unit.
// Depends on osp_pkg for the field widths.
interface osp_in_if import osp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [POS_W-1:0]  position;
  logic [WD_W-1:0]   write_data;

  modport source(output valid, output operation, output position, output write_data,
                 input ready);
  modport sink(input valid, input operation, input position, input write_data,
               output ready);
endinterface

interface osp_out_if import osp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RD_W-1:0]      read_data;
  logic [SLOT_W-1:0]    slot_used;
  logic [CNT_OUT_W-1:0] count_now;
  logic [ST_W-1:0]      status;

  modport source(output valid, output read_data, output slot_used, output count_now,
                 output status, input ready);
  modport sink(input valid, input read_data, input slot_used, input count_now,
               input status, output ready);
endinterface

// ----- sv/osp_ctrl.sv -----
// Sequencing state machine for the ordered slot pool unit.
// Depends on osp_pkg; drives osp_dp through the command struct.
module osp_ctrl import osp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  osp_stat_t stat,
  output osp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_LOOKUP = 8'b0000_1000,
    S_ACCESS = 8'b0001_0000,
    S_SHIFT  = 8'b0010_0000,
    S_PLACE  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.setup = 1'b1;
        if (stat.is_alloc) begin
          state_nxt = stat.full ? S_DONE : S_SHIFT;
        end else if (stat.is_acc) begin
          state_nxt = stat.in_range ? S_LOOKUP : S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_ACCESS;
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = stat.is_del ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        cmd.scan_en  = stat.is_alloc;
        // allocation also waits for the free-slot search
        if (!stat.sh_busy && (!stat.is_alloc || stat.found)) begin
          state_nxt = stat.is_alloc ? S_PLACE : S_DONE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/osp_dp.sv -----
// Datapath for the ordered slot pool unit: payload, order index and free-map
// memories, shift and scan counters, live count and result register. Uses osp_pkg.
module osp_dp import osp_pkg::*; #(
  parameter int SLOTS      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [POS_W-1:0]     in_position,
  input  logic [WD_W-1:0]      in_write_data,
  input  osp_cmd_t             cmd,
  output osp_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RD_W-1:0]      out_read_data,
  output logic [SLOT_W-1:0]    out_slot_used,
  output logic [CNT_OUT_W-1:0] out_count_now,
  output logic [ST_W-1:0]      out_status
);

  localparam int IDXW = $clog2(SLOTS);
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;

  // captured item
  op_code_t         op_r;
  logic [POS_W-1:0] pos_r;
  logic [WD_W-1:0]  wdata_r;

  logic [CNTW-1:0] cnt_r;
  logic [IDXW-1:0] at_r;
  logic [CNTW-1:0] k_r;
  logic [CNTW-1:0] lim_r;
  status_t         st_r;
  logic [IDXW-1:0] slot_r;
  logic [IDXW-1:0] clr_r;

  logic is_app, is_ins, is_del, is_get, is_set, is_alloc, is_acc;
  logic in_range, full;

  // memories
  logic [IDXW-1:0]       idx_mem [SLOTS];
  logic [DATA_WIDTH-1:0] pay_mem [SLOTS];
  logic                  fm_mem  [SLOTS];

  logic [IDXW-1:0]       idx_rdata_r;
  logic [DATA_WIDTH-1:0] pay_rdata_r;
  logic                  fm_rdata_r;

  // shift and scan
  logic            mv_pend_r;
  logic [IDXW-1:0] mv_dst_r;
  logic [CNTW-1:0] k_inc, k_dec;
  logic            sh_more, sh_issue;
  logic [IDXW-1:0] sh_src;

  logic            scan_pend_r, found_r, hit, scan_issue;
  logic [IDXW-1:0] scan_addr_r, scan_tag_r, free_slot_r;

  logic                  idx_re, idx_we, pay_re, pay_we, fm_we, fm_wdata;
  logic [IDXW-1:0]       idx_raddr, idx_waddr, idx_wdata, pay_waddr, fm_waddr;
  logic [DATA_WIDTH-1:0] pay_wdata;

  logic                 out_valid_r;
  logic [RD_W-1:0]      rd_r;
  logic [SLOT_W-1:0]    slot_out_r;
  logic [CNT_OUT_W-1:0] cnt_out_r;
  status_t              st_out_r;

  assign is_app   = (op_r == OP_APPEND);
  assign is_ins   = (op_r == OP_INSERT);
  assign is_del   = (op_r == OP_DELETE);
  assign is_get   = (op_r == OP_GET);
  assign is_set   = (op_r == OP_SET);
  assign is_alloc = is_app | is_ins;
  assign is_acc   = is_del | is_get | is_set;
  assign in_range = (CMPW'(pos_r) < CMPW'(cnt_r));
  assign full     = (cnt_r == CNTW'(SLOTS));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      pos_r   <= in_position;
      wdata_r <= in_write_data;
    end
  end

  // shift: insert moves entries up from the top, delete moves them down
  assign k_inc    = k_r + CNTW'(1);
  assign k_dec    = k_r - CNTW'(1);
  assign sh_more  = is_alloc ? (k_r > CNTW'(at_r)) : (k_inc < lim_r);
  assign sh_issue = cmd.shift_en && sh_more;
  assign sh_src   = is_alloc ? IDXW'(k_dec) : IDXW'(k_inc);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      at_r  <= (is_ins && in_range) ? IDXW'(pos_r) : IDXW'(cnt_r);
      k_r   <= is_alloc ? cnt_r : CNTW'(pos_r);
      lim_r <= cnt_r;
      if (is_alloc && full) begin
        st_r <= ST_FULL;
      end else if (is_acc && !in_range) begin
        st_r <= ST_RANGE;
      end else begin
        st_r <= ST_OK;
      end
    end else if (sh_issue) begin
      k_r <= is_alloc ? k_dec : k_inc;
    end
    if (sh_issue) begin
      mv_dst_r <= IDXW'(k_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_pend_r <= 1'b0;
    end else begin
      mv_pend_r <= sh_issue;
    end
  end

  // order index memory
  assign idx_re    = cmd.lookup || sh_issue;
  assign idx_raddr = cmd.lookup ? IDXW'(pos_r) : sh_src;
  assign idx_we    = mv_pend_r || cmd.place;
  assign idx_waddr = cmd.place ? at_r : mv_dst_r;
  assign idx_wdata = cmd.place ? free_slot_r : idx_rdata_r;

  always_ff @(posedge clk) begin
    if (idx_we) begin
      idx_mem[idx_waddr] <= idx_wdata;
    end
    if (idx_re) begin
      idx_rdata_r <= idx_mem[idx_raddr];
    end
  end

  // payload memory
  assign pay_re    = cmd.access && is_get;
  assign pay_we    = (cmd.access && (is_set || is_del)) || cmd.place;
  assign pay_waddr = cmd.place ? free_slot_r : idx_rdata_r;
  assign pay_wdata = (cmd.access && is_del) ? '0 : DATA_WIDTH'(wdata_r);

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    if (pay_re) begin
      pay_rdata_r <= pay_mem[idx_rdata_r];
    end
  end

  // free map: one bit per slot, set = free
  assign fm_we    = cmd.clr_en || cmd.place || (cmd.access && is_del);
  assign fm_waddr = cmd.clr_en ? clr_r : (cmd.place ? free_slot_r : idx_rdata_r);
  assign fm_wdata = !cmd.place;

  // scan read data is registered, so it lags its address
  assign hit        = scan_pend_r && fm_rdata_r && !found_r;
  assign scan_issue = cmd.scan_en && !found_r && !hit;

  always_ff @(posedge clk) begin
    if (fm_we) begin
      fm_mem[fm_waddr] <= fm_wdata;
    end
    if (scan_issue) begin
      fm_rdata_r <= fm_mem[scan_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pend_r <= 1'b0;
      found_r     <= 1'b0;
      scan_addr_r <= '0;
      clr_r       <= '0;
    end else begin
      if (cmd.clr_en) begin
        clr_r <= clr_r + IDXW'(1);
      end
      if (cmd.setup) begin
        scan_pend_r <= 1'b0;
        found_r     <= 1'b0;
        scan_addr_r <= '0;
      end else if (cmd.scan_en) begin
        scan_pend_r <= scan_issue;
        if (hit) begin
          found_r <= 1'b1;
        end
        if (scan_issue) begin
          scan_addr_r <= (scan_addr_r == IDXW'(SLOTS - 1)) ? '0 : scan_addr_r + IDXW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      scan_tag_r <= scan_addr_r;
    end
    if (cmd.scan_en && hit) begin
      free_slot_r <= scan_tag_r;
    end
  end

  // live count and addressed slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.place) begin
      cnt_r <= cnt_r + CNTW'(1);
    end else if (cmd.access && is_del) begin
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      slot_r <= '0;
    end else if (cmd.access) begin
      slot_r <= idx_rdata_r;
    end else if (cmd.place) begin
      slot_r <= free_slot_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rd_r       <= (is_get && st_r == ST_OK) ? RD_W'(pay_rdata_r) : '0;
      slot_out_r <= SLOT_W'(slot_r);
      cnt_out_r  <= CNT_OUT_W'(cnt_r);
      st_out_r   <= st_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = rd_r;
  assign out_slot_used = slot_out_r;
  assign out_count_now = cnt_out_r;
  assign out_status    = st_out_r;

  always_comb begin
    stat          = '0;
    stat.clr_last = (clr_r == IDXW'(SLOTS - 1));
    stat.is_alloc = is_alloc;
    stat.is_acc   = is_acc;
    stat.is_del   = is_del;
    stat.full     = full;
    stat.in_range = in_range;
    stat.sh_busy  = sh_more || mv_pend_r;
    stat.found    = found_r;
    stat.out_free = !out_valid_r || out_ready;
  end

endmodule

// ----- sv/ordered_slot_pool_unit.sv -----
// Channel    | Dir | Handshake    | Payload
// in_ch      | in  | valid/ready  | operation, position, write_data
// out_ch     | out | valid/ready  | read_data, slot_used, count_now, status
//
// One item at a time. Get and set go through decode, lookup, access and done;
// delete adds a shift that moves each later entry down. Append and insert go
// through decode, shift and place; the index shift and the free-map search run
// side by side. After reset a clearing pass marks every slot free, in_ch not ready.
// A result waits in the output register while out_ch stalls; the next item
// is taken meanwhile and held in its last cycle until the register is free.
// Top level of the ordered slot pool unit; uses osp_pkg, osp_if, osp_ctrl, osp_dp.
`include "ordered_slot_pool_unit_defines.svh"

module ordered_slot_pool_unit import osp_pkg::*; #(
  parameter int SLOTS      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  osp_in_if.sink   in_ch,
  osp_out_if.source out_ch
);

  osp_cmd_t  cmd;
  osp_stat_t stat;

  osp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  osp_dp #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_operation  (in_ch.operation),
    .in_position   (in_ch.position),
    .in_write_data (in_ch.write_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_read_data (out_ch.read_data),
    .out_slot_used (out_ch.slot_used),
    .out_count_now (out_ch.count_now),
    .out_status    (out_ch.status)
  );

  `OSP_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "taken while busy")
  `OSP_ASSERT_IMPLY(a_place_found, cmd.place, stat.found, "slot placed before search ended")
  `OSP_ASSERT_IMPLY(a_load_free, cmd.load_result, stat.out_free, "result overwrote a pending one")
  `OSP_ASSERT_IMPLY(a_out_from_load, $rose(out_ch.valid), $past(cmd.load_result), "stray result")

endmodule

// ----- verif/ordered_slot_pool_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ordered_slot_pool_unit: directed and random items,
// random gaps and stalls, one long output hold-off. Depends on osp_pkg and osp_if.
module ordered_slot_pool_unit_test;
  import osp_pkg::*;

  localparam int SLOTS        = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_AT      = 300;   // result index where the long hold-off starts
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 100;

  localparam op_code_t OP_SPARE_5 = 3'd5;
  localparam op_code_t OP_SPARE_6 = 3'd6;
  localparam op_code_t OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [RD_W-1:0]      read_data;
    logic [SLOT_W-1:0]    slot_used;
    logic [CNT_OUT_W-1:0] count_now;
    status_t              status;
  } pool_result_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} load_mode_t;

  // Tracks the pool contents and the queue of results still owed by the block.
  class pool_scoreboard_t;
    logic [DATA_WIDTH-1:0] payload [SLOTS];
    logic [SLOT_W-1:0]     order [SLOTS];
    logic [SLOTS-1:0]      free_slots;
    int unsigned           live;
    pool_result_t          pending [$];
    int unsigned           errors;

    function new();
      for (int k = 0; k < SLOTS; k++) begin
        payload[k] = '0;
        order[k] = '0;
      end
      free_slots = '1;
      live = 0;
      errors = 0;
    endfunction

    function void note_input(op_code_t op, logic [POS_W-1:0] pos, logic [WD_W-1:0] wd);
      pool_result_t res;
      int unsigned at;
      int unsigned slot;
      res = '0;
      case (op)
        OP_APPEND, OP_INSERT: begin
          if (live >= SLOTS) begin
            res.status = ST_FULL;
          end else begin
            at = (op == OP_INSERT && pos < live) ? pos : live;
            slot = 0;
            for (int k = SLOTS - 1; k >= 0; k--) begin
              if (free_slots[k]) slot = k;
            end
            free_slots[slot] = 1'b0;
            payload[slot] = wd[DATA_WIDTH-1:0];
            for (int k = live; k > at; k--) order[k] = order[k-1];
            order[at] = SLOT_W'(slot);
            live++;
            res.slot_used = SLOT_W'(slot);
          end
        end
        OP_DELETE, OP_GET, OP_SET: begin
          if (pos >= live) begin
            res.status = ST_RANGE;
          end else begin
            slot = 32'(order[pos]);
            res.slot_used = SLOT_W'(slot);
            if (op == OP_DELETE) begin
              payload[slot] = '0;
              free_slots[slot] = 1'b1;
              for (int k = pos; k + 1 < live; k++) order[k] = order[k+1];
              live--;
            end else if (op == OP_GET) begin
              res.read_data = payload[slot];
            end else begin
              payload[slot] = wd[DATA_WIDTH-1:0];
            end
          end
        end
        default: ;  // spare codes leave the pool alone
      endcase
      res.count_now = CNT_OUT_W'(live);
      pending.push_back(res);
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      if (pending.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
        errors++;
      end
      if (got.slot_used !== want.slot_used) begin
        $error("slot_used: expected %0d, got %0d", want.slot_used, got.slot_used);
        errors++;
      end
      if (got.count_now !== want.count_now) begin
        $error("count_now: expected %0d, got %0d", want.count_now, got.count_now);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   no_gaps = 1'b0;
  int unsigned idle_cycles = 0;
  pool_scoreboard_t pool_sb = new();

  osp_in_if  in_ch();
  osp_out_if out_ch();

  ordered_slot_pool_unit #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Offer one item after a random gap and hold it until taken.
  task automatic send_item(op_code_t op, logic [POS_W-1:0] pos, logic [WD_W-1:0] wd);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.position   <= pos;
    in_ch.write_data <= wd;
    do @(posedge clk); while (!in_ch.ready);
    pool_sb.note_input(op, pos, wd);
  endtask

  // Result side: random stalls, one long hold-off so the block backs up.
  initial begin
    int unsigned stall;
    int unsigned results_taken;
    results_taken = 0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (results_taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      pool_sb.check_result('{out_ch.read_data, out_ch.slot_used,
                             out_ch.count_now, out_ch.status});
      results_taken++;
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    load_mode_t mode;
    int unsigned mix_left;
    int unsigned r;
    op_code_t op;
    logic [POS_W-1:0] pos;
    logic [WD_W-1:0] wd;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_APPEND;
    in_ch.position   <= '0;
    in_ch.write_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pool, insert past the count, shifts, clears, spare codes
    send_item(OP_GET,    6'd0,  32'h0);
    send_item(OP_DELETE, 6'd63, 32'h0);
    send_item(OP_SET,    6'd0,  32'hFFFF_FFFF);
    send_item(OP_INSERT, 6'd5,  32'hFFFF_FFFF);
    send_item(OP_APPEND, 6'd63, 32'h0000_0000);
    send_item(OP_INSERT, 6'd0,  32'hA5A5_A5A5);
    send_item(OP_INSERT, 6'd1,  32'h5A5A_5A5A);
    send_item(OP_INSERT, 6'd4,  32'h0000_0001);
    for (int k = 0; k < 5; k++) send_item(OP_GET, k[POS_W-1:0], 32'h0);
    send_item(OP_SET,    6'd2,  32'h1234_5678);
    send_item(OP_GET,    6'd2,  32'h0);
    send_item(OP_DELETE, 6'd0,  32'h0);
    send_item(OP_DELETE, 6'd3,  32'h0);
    send_item(OP_APPEND, 6'd0,  32'h8000_0000);
    send_item(OP_GET,    6'd3,  32'h0);
    send_item(OP_GET,    6'd63, 32'h0);
    send_item(OP_SPARE_5, 6'd63, 32'hFFFF_FFFF);
    send_item(OP_SPARE_6, 6'd0,  32'h0);
    send_item(OP_SPARE_7, 6'd1,  32'hFFFF_FFFF);

    // random: swing between filling to full and draining to empty, with a mixed stretch after each drain
    mode = MODE_FILL;
    mix_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_gaps = ((n / 100) % 4) == 3;
      case (mode)
        MODE_FILL: if (pool_sb.live == SLOTS && $urandom_range(0, 5) == 0) mode = MODE_DRAIN;
        MODE_DRAIN: if (pool_sb.live == 0 && $urandom_range(0, 3) == 0) begin
          mode = MODE_MIX;
          mix_left = $urandom_range(40, 120);
        end
        default: if (mix_left == 0) mode = MODE_FILL; else mix_left--;
      endcase

      r = $urandom_range(0, 99);
      case (mode)
        MODE_FILL:
          op = r < 45 ? OP_APPEND : r < 85 ? OP_INSERT : r < 92 ? OP_GET :
               r < 97 ? OP_SET : OP_DELETE;
        MODE_DRAIN:
          op = r < 55 ? OP_DELETE : r < 70 ? OP_GET : r < 80 ? OP_SET :
               r < 90 ? OP_APPEND : OP_INSERT;
        default: begin
          if (r < 3) begin
            case ($urandom_range(0, 2))
              0: op = OP_SPARE_5;
              1: op = OP_SPARE_6;
              default: op = OP_SPARE_7;
            endcase
          end else begin
            case ($urandom_range(0, 4))
              0: op = OP_APPEND;
              1: op = OP_INSERT;
              2: op = OP_DELETE;
              3: op = OP_GET;
              default: op = OP_SET;
            endcase
          end
        end
      endcase

      if (pool_sb.live > 0 && $urandom_range(0, 4) != 0)
        pos = POS_W'($urandom_range(0, pool_sb.live - 1));
      else
        pos = POS_W'($urandom_range(0, SLOTS - 1));

      case ($urandom_range(0, 9))
        0: wd = '0;
        1: wd = '1;
        default: wd = $urandom;
      endcase
      send_item(op, pos, wd);
    end
    in_ch.valid <= 1'b0;

    while (pool_sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pool_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
